@@ src/fbca_pkg.sv @@
// Shared types and constants of the FFT bin channel aggregator.
`default_nettype none
package fbca_pkg;

  localparam int unsigned ACC_W      = 40;  // channel sums and bin positions
  localparam int unsigned FRAC_W     = 16;  // fraction bits of a position
  localparam int unsigned CH_NUM_W   = 6;   // channel_number field
  localparam int unsigned BPV_W      = 11;  // bins_per_vector register
  localparam int unsigned NCH_W      = 7;   // num_channels register
  localparam int unsigned FIRST_W    = 28;  // first_bin_pos register
  localparam int unsigned STEP_W     = 24;  // bin_step register
  localparam int unsigned LIMIT_W    = 27;  // band_limit register
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 28;

  localparam logic [CFG_IDX_W-1:0] REG_BINS_PER_VECTOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BIN_POS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_STEP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LIMIT      = 3'd4;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_EMIT
  } state_e;

  // Result of mapping one bin onto the channel grid.
  typedef struct packed {
    logic hit;       // bin lies inside the band and in a live channel
    logic last_bin;  // bin closes the vector
  } map_flags_t;

endpackage
`default_nettype wire

@@ src/fft_bin_channel_aggregator_unit.sv @@
// Timing: a bin's sum is written back in the cycle after the bin is taken. After the last
// bin of a vector, a flush state lets it land; then each channel sum is read from memory
// into the output register. Throughput: one bin per cycle within a vector, then one channel
// word per cycle unless the output stalls; the input is held until the final sum is loaded.
// Reset: asynchronous, active low; registers return to their defaults and all
// channel sums read as zero.
`default_nettype none
module fft_bin_channel_aggregator_unit #(
  parameter int unsigned MAX_BINS     = 1024,
  parameter int unsigned MAX_CHANNELS = 64,
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [fbca_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [fbca_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // bits: bin_value
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // bits: channel_sum
  output logic      [fbca_pkg::ACC_W-1:0]           m_axis_tdata,
  // bits: channel_number
  output logic      [fbca_pkg::CH_NUM_W-1:0]        m_axis_tuser,
  output logic                                      m_axis_tlast
);
  import fbca_pkg::*;

  localparam int unsigned CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned MC_W     = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned EFF_CH_W = (MC_W > NCH_W) ? MC_W : NCH_W;

  // configuration
  logic [BPV_W-1:0]   bpv_q;
  logic [NCH_W-1:0]   nch_q;
  logic [FIRST_W-1:0] first_q;
  logic [STEP_W-1:0]  step_q;
  logic [LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpv_q   <= BPV_W'(1024);
      nch_q   <= NCH_W'(64);
      first_q <= '0;
      step_q  <= STEP_W'(65536);
      limit_q <= LIMIT_W'(4194304);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BINS_PER_VECTOR: bpv_q   <= cfg_wdata_i[BPV_W-1:0];
        REG_NUM_CHANNELS:    nch_q   <= cfg_wdata_i[NCH_W-1:0];
        REG_FIRST_BIN_POS:   first_q <= cfg_wdata_i[FIRST_W-1:0];
        REG_BIN_STEP:        step_q  <= cfg_wdata_i[STEP_W-1:0];
        REG_BAND_LIMIT:      limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [EFF_CH_W-1:0] eff_ch;
  always_comb begin
    if (nch_q == '0) begin
      eff_ch = EFF_CH_W'(1);
    end else if (EFF_CH_W'(nch_q) > EFF_CH_W'(MAX_CHANNELS)) begin
      eff_ch = EFF_CH_W'(MAX_CHANNELS);
    end else begin
      eff_ch = EFF_CH_W'(nch_q);
    end
  end

  // control state
  state_e              state_q, state_d;
  logic                in_acc;
  logic [CH_IDX_W-1:0] map_ch;
  map_flags_t          map_flags;

  assign s_axis_tready = (state_q == ST_ACCUM);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  fbca_bin_map #(
    .MAX_BINS (MAX_BINS),
    .CH_IDX_W (CH_IDX_W),
    .EFF_CH_W (EFF_CH_W)
  ) u_bin_map (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (in_acc),
    .bins_per_vector_i (bpv_q),
    .first_bin_pos_i   (first_q),
    .bin_step_i        (step_q),
    .band_limit_i      (limit_q),
    .eff_ch_i          (eff_ch),
    .ch_o              (map_ch),
    .flags_o           (map_flags)
  );

  // summing stage
  logic                s1_valid_q;
  logic [CH_IDX_W-1:0] s1_ch_q;
  logic [ACC_W-1:0]    s1_val_q;
  logic                wr_fwd_q;
  logic [CH_IDX_W-1:0] wr_ch_q;
  logic [ACC_W-1:0]    wr_sum_q;
  logic [ACC_W-1:0]    mem_rdata;
  logic [ACC_W-1:0]    old_sum;
  logic [ACC_W-1:0]    new_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wr_fwd_q   <= 1'b0;
    end else begin
      s1_valid_q <= in_acc && map_flags.hit;
      wr_fwd_q   <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ch_q  <= map_ch;
      s1_val_q <= {{(ACC_W-SAMPLE_WIDTH){s_axis_tdata[SAMPLE_WIDTH-1]}},
                   s_axis_tdata[SAMPLE_WIDTH-1:0]};
    end
    if (s1_valid_q) begin
      wr_ch_q  <= s1_ch_q;
      wr_sum_q <= new_sum;
    end
  end

  // forward the sum written last cycle; the memory read missed it
  assign old_sum = (wr_fwd_q && (wr_ch_q == s1_ch_q)) ? wr_sum_q : mem_rdata;
  assign new_sum = old_sum + s1_val_q;

  // emission
  logic [EFF_CH_W-1:0] k_q, k_d;
  logic                rd_pend_q, rd_pend_d;
  logic [EFF_CH_W-1:0] rd_num_q;
  logic                rd_last_q;
  logic                load;
  logic                issue;
  logic                issue_last;
  logic                out_valid_q, out_valid_d;
  logic [ACC_W-1:0]    out_sum_q;
  logic [CH_NUM_W-1:0] out_num_q;
  logic                out_last_q;

  always_comb begin
    load        = rd_pend_q && (!out_valid_q || m_axis_tready);
    issue       = 1'b0;
    issue_last  = (k_q + EFF_CH_W'(1)) == eff_ch;
    state_d     = state_q;
    k_d         = k_q;
    rd_pend_d   = rd_pend_q && !load;
    out_valid_d = load || (out_valid_q && !m_axis_tready);

    case (state_q)
      ST_ACCUM: begin
        if (in_acc && map_flags.last_bin) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // let the final bin land in memory before reading it back
        k_d     = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (k_q < eff_ch) begin
          if (!rd_pend_q || load) begin
            issue     = 1'b1;
            rd_pend_d = 1'b1;
            k_d       = k_q + EFF_CH_W'(1);
          end
        end else if (!rd_pend_q || load) begin
          state_d = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      k_q         <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_num_q  <= k_q;
      rd_last_q <= issue_last;
    end
    if (load) begin
      out_sum_q  <= mem_rdata;
      out_num_q  <= CH_NUM_W'(rd_num_q);
      out_last_q <= rd_last_q;
    end
  end

  fbca_acc_mem #(
    .DEPTH  (MAX_CHANNELS),
    .ADDR_W (CH_IDX_W)
  ) u_acc_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (s1_valid_q),
    .waddr_i (s1_ch_q),
    .wdata_i (new_sum),
    .re_i    ((in_acc && map_flags.hit) || issue),
    .raddr_i (issue ? k_q[CH_IDX_W-1:0] : map_ch),
    .clr_i   (issue && issue_last),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sum_q;
  assign m_axis_tuser  = out_num_q;
  assign m_axis_tlast  = out_last_q;

  // no bin is summed while channel sums are read out
  a_no_sum_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !s1_valid_q)
    else $error("bin summed during emission");

  // memory port is never shared between a bin and a channel read
  a_single_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(issue && in_acc))
    else $error("read port conflict");

  // a pending read is never dropped: it lands in the output or waits
  a_pend_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_pend_q && out_valid_q && !m_axis_tready) |=> rd_pend_q)
    else $error("pending channel read lost");

  // the sums are cleared with the read of the final channel
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && issue_last) |=> (state_q == ST_EMIT) && rd_pend_q && rd_last_q)
    else $error("clear out of step with final channel");

endmodule
`default_nettype wire

@@ src/fbca_bin_map.sv @@
// Bin counter and position tracker that maps each bin onto a channel.
`default_nettype none
module fbca_bin_map #(
  parameter int unsigned MAX_BINS = 1024,
  parameter int unsigned CH_IDX_W = 6,
  parameter int unsigned EFF_CH_W = 7
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic [fbca_pkg::BPV_W-1:0]     bins_per_vector_i,
  input  wire logic [fbca_pkg::FIRST_W-1:0]   first_bin_pos_i,
  input  wire logic [fbca_pkg::STEP_W-1:0]    bin_step_i,
  input  wire logic [fbca_pkg::LIMIT_W-1:0]   band_limit_i,
  input  wire logic [EFF_CH_W-1:0]            eff_ch_i,
  output logic      [CH_IDX_W-1:0]            ch_o,
  output fbca_pkg::map_flags_t                flags_o
);
  import fbca_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BINS);
  localparam int unsigned MB_W  = $clog2(MAX_BINS + 1);
  localparam int unsigned BW    = (MB_W > BPV_W) ? MB_W : BPV_W;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0] pos_q, pos_d;
  logic [ACC_W-1:0] pos;
  logic [BW-1:0]    eff_bins;
  logic [BW-1:0]    cnt_next;
  logic [BW-1:0]    bpv_ext;
  logic             in_band;
  logic             ch_ok;

  always_comb begin
    bpv_ext = BW'(bins_per_vector_i);
    if (bpv_ext == '0) begin
      eff_bins = BW'(1);
    end else if (bpv_ext > BW'(MAX_BINS)) begin
      eff_bins = BW'(MAX_BINS);
    end else begin
      eff_bins = bpv_ext;
    end

    // reload the start position at the head of every vector
    if (cnt_q == '0) begin
      pos = {{(ACC_W-FIRST_W){first_bin_pos_i[FIRST_W-1]}}, first_bin_pos_i};
    end else begin
      pos = pos_q;
    end

    in_band = !pos[ACC_W-1] && (pos < ACC_W'(band_limit_i));
    ch_ok   = pos[ACC_W-1:FRAC_W] < (ACC_W-FRAC_W)'(eff_ch_i);

    cnt_next         = BW'(cnt_q) + BW'(1);
    flags_o.hit      = in_band && ch_ok;
    flags_o.last_bin = cnt_next >= eff_bins;
    ch_o             = pos[FRAC_W +: CH_IDX_W];

    pos_d = pos_q;
    cnt_d = cnt_q;
    if (accept_i) begin
      pos_d = pos + ACC_W'(bin_step_i);
      cnt_d = flags_o.last_bin ? '0 : CNT_W'(cnt_next);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

endmodule
`default_nettype wire

@@ src/fbca_acc_mem.sv @@
// Channel accumulator memory with per-entry valid bits and registered read.
`default_nettype none
module fbca_acc_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        we_i,
  input  wire logic [ADDR_W-1:0]           waddr_i,
  input  wire logic [fbca_pkg::ACC_W-1:0]  wdata_i,
  input  wire logic                        re_i,
  input  wire logic [ADDR_W-1:0]           raddr_i,
  input  wire logic                        clr_i,
  output logic      [fbca_pkg::ACC_W-1:0]  rdata_o
);
  import fbca_pkg::*;

  logic [ACC_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q, vld_d;
  logic [ACC_W-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (we_i) begin
      vld_d[waddr_i] = 1'b1;
    end
    if (clr_i) begin
      vld_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  // entries not written since the last clear read as zero
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule
`default_nettype wire

@@ tb/fft_bin_channel_aggregator_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the FFT bin channel aggregator: directed table, then random phases.
module fft_bin_channel_aggregator_unit_test;
  import fbca_pkg::*;

  localparam int unsigned MAX_BINS_C       = 1024;
  localparam int unsigned MAX_CH_C         = 64;
  localparam int unsigned SAMPLE_W         = 24;
  localparam int unsigned BIN_BUS_W        = ((SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned ONE_CH           = 1 << FRAC_W;  // one channel width in Q.16
  localparam int unsigned RANDOM_BINS      = 290;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT      = 1000000;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned PLAN_ROWS        = 41;

  // indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {
    ROW_WRITE,
    ROW_BIN
  } row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;   // register value, or bin value in the low bits
    logic                   typed;  // sum below is the known answer for a one-channel vector
    logic [ACC_W-1:0]       sum;
  } plan_row_t;

  typedef struct packed {
    logic [ACC_W-1:0]    sum;
    logic [CH_NUM_W-1:0] chan;
    logic                last;
  } chan_word_t;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  bin_valid = 1'b0;
  logic                  bin_ready;
  logic [BIN_BUS_W-1:0]  bin_data  = '0;
  logic                  word_valid;
  logic                  word_ready = 1'b0;
  logic [ACC_W-1:0]      word_sum;
  logic [CH_NUM_W-1:0]   word_chan;
  logic                  word_last;

  // shadow of the block: registers, bin position and channel sums
  logic [BPV_W-1:0]          bpv_reg;
  logic [NCH_W-1:0]          nch_reg;
  logic [FIRST_W-1:0]        first_reg;
  logic [STEP_W-1:0]         step_reg;
  logic [LIMIT_W-1:0]        limit_reg;
  int unsigned               bin_idx;
  logic signed [ACC_W-1:0]   bin_pos;
  logic [ACC_W-1:0]          chan_acc [MAX_CH_C];

  chan_word_t  chan_words_due [$];
  chan_word_t  due;
  plan_row_t   plan [PLAN_ROWS];

  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;
  int unsigned words_seen  = 0;
  int unsigned bins_sent   = 0;
  int unsigned cfg_writes  = 0;
  bit          cfg_open    = 1'b0;
  bit          quiet_tail  = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned gap_left    = 0;

  always #1 clk_i = ~clk_i;

  fft_bin_channel_aggregator_unit #(
    .MAX_BINS     (MAX_BINS_C),
    .MAX_CHANNELS (MAX_CH_C),
    .SAMPLE_WIDTH (SAMPLE_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (bin_valid),
    .s_axis_tready (bin_ready),
    .s_axis_tdata  (bin_data),
    .m_axis_tvalid (word_valid),
    .m_axis_tready (word_ready),
    .m_axis_tdata  (word_sum),
    .m_axis_tuser  (word_chan),
    .m_axis_tlast  (word_last)
  );

  function automatic int unsigned live_bins();
    if (bpv_reg == 0) return 1;
    if (bpv_reg > MAX_BINS_C) return MAX_BINS_C;
    return 32'(bpv_reg);
  endfunction

  function automatic int unsigned live_channels();
    if (nch_reg == 0) return 1;
    if (nch_reg > MAX_CH_C) return MAX_CH_C;
    return 32'(nch_reg);
  endfunction

  // Map one bin onto the channel grid; at the end of a vector queue every channel sum.
  task automatic sum_bin(input logic [SAMPLE_W-1:0] v);
    int unsigned nch;
    int unsigned ch;
    int unsigned k;
    nch = live_channels();
    if (bin_idx == 0) bin_pos = {{(ACC_W - FIRST_W){first_reg[FIRST_W-1]}}, first_reg};
    if (!bin_pos[ACC_W-1] && bin_pos < $signed({{(ACC_W - LIMIT_W){1'b0}}, limit_reg})) begin
      ch = int'(bin_pos[ACC_W-1:FRAC_W]);
      if (ch < nch) chan_acc[ch] = chan_acc[ch] + {{(ACC_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
    end
    bin_pos = bin_pos + $signed({{(ACC_W - STEP_W){1'b0}}, step_reg});
    bin_idx++;
    if (bin_idx >= live_bins()) begin
      for (k = 0; k < nch; k++) begin
        chan_words_due.push_back('{chan_acc[k], CH_NUM_W'(k), (k + 1 == nch)});
      end
      for (k = 0; k < MAX_CH_C; k++) chan_acc[k] = '0;
      bin_idx = 0;
    end
  endtask

  // Hold the input until every channel word is out and the pipeline has drained.
  task automatic settle();
    bin_valid <= 1'b0;
    while (chan_words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    if (!cfg_open) begin
      settle();
      cfg_open = 1'b1;
    end
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      REG_BINS_PER_VECTOR: bpv_reg   = data[BPV_W-1:0];
      REG_NUM_CHANNELS:    nch_reg   = data[NCH_W-1:0];
      REG_FIRST_BIN_POS:   first_reg = data[FIRST_W-1:0];
      REG_BIN_STEP:        step_reg  = data[STEP_W-1:0];
      REG_BAND_LIMIT:      limit_reg = data[LIMIT_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic send_bin(input logic [SAMPLE_W-1:0] v);
    if (cfg_open) begin
      cfg_we   <= 1'b0;
      cfg_open = 1'b0;
    end
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      bin_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    bin_valid <= 1'b1;
    bin_data  <= BIN_BUS_W'(v);
    do begin
      @(posedge clk_i);
    end while (!bin_ready);
    sum_bin(v);
    bins_sent++;
  endtask

  // Keep the low bits of a register value; sometimes fill the unused upper bits with noise.
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] value,
                                                      input int unsigned width);
    logic [CFG_DATA_W-1:0] keep;
    keep = (CFG_DATA_W'(1) << width) - 1'b1;
    if ($urandom_range(0, 3) == 0) return (value & keep) | (CFG_DATA_W'($urandom()) & ~keep);
    return value & keep;
  endfunction

  // One random phase: new settings while idle, then a run of bins, mostly whole vectors.
  task automatic run_phase(input bit crowd, input int unsigned room);
    int unsigned pick;
    int unsigned nbins;
    int unsigned plan_bins;
    logic [SAMPLE_W-1:0] v;
    if (crowd) begin
      write_reg(REG_BINS_PER_VECTOR, CFG_DATA_W'($urandom_range(1, 3)));
      write_reg(REG_NUM_CHANNELS, CFG_DATA_W'(MAX_CH_C));
    end else begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       pick = 0;
          1:       pick = 1;
          2:       pick = MAX_BINS_C;
          3:       pick = (1 << BPV_W) - 1;
          4, 5:    pick = $urandom_range(13, 48);
          default: pick = $urandom_range(1, 12);
        endcase
        write_reg(REG_BINS_PER_VECTOR, with_junk(CFG_DATA_W'(pick), BPV_W));
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       pick = 0;
          1:       pick = MAX_CH_C;
          2:       pick = (1 << NCH_W) - 1;
          3:       pick = 1;
          4, 5:    pick = $urandom_range(17, 63);
          default: pick = $urandom_range(1, 16);
        endcase
        write_reg(REG_NUM_CHANNELS, with_junk(CFG_DATA_W'(pick), NCH_W));
      end
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 9))
        0:       write_reg(REG_FIRST_BIN_POS, {1'b1, {(FIRST_W - 1){1'b0}}});
        1:       write_reg(REG_FIRST_BIN_POS, {1'b0, {(FIRST_W - 1){1'b1}}});
        2:       write_reg(REG_FIRST_BIN_POS, CFG_DATA_W'($urandom()));
        default: write_reg(REG_FIRST_BIN_POS,
                           CFG_DATA_W'(int'($urandom_range(0, 8 * ONE_CH)) - int'(2 * ONE_CH)));
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 9))
        0:       pick = 0;
        1:       pick = (1 << STEP_W) - 1;
        2:       pick = $urandom();
        3, 4:    pick = ONE_CH;
        default: pick = $urandom_range(0, 3 * ONE_CH);
      endcase
      write_reg(REG_BIN_STEP, with_junk(CFG_DATA_W'(pick), STEP_W));
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 9))
        0:       pick = 0;
        1:       pick = (1 << LIMIT_W) - 1;
        2:       pick = $urandom();
        default: pick = $urandom_range(0, (live_channels() + 2) * ONE_CH);
      endcase
      write_reg(REG_BAND_LIMIT, with_junk(CFG_DATA_W'(pick), LIMIT_W));
    end
    if ($urandom_range(0, 9) == 0) begin
      write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom()));
    end

    nbins = live_bins();
    if (nbins > 64) begin
      // long vectors: send a slice only, a later phase may shorten the vector
      plan_bins = $urandom_range(1, 40);
    end else begin
      plan_bins = nbins * $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) plan_bins += $urandom_range(1, nbins);
    end
    // stop at the planned total of the run
    if (plan_bins > room) plan_bins = room;
    if (crowd) long_hold_req = 1'b1;
    repeat (plan_bins) begin
      case ($urandom_range(0, 15))
        0:       v = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        1:       v = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        2:       v = '0;
        default: v = SAMPLE_W'($urandom());
      endcase
      send_bin(v);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [ACC_W-1:0] want,
                               input logic [ACC_W-1:0] got);
    if (mismatches < MAX_REPORTS) begin
      $display("mismatch at channel word %0d: %s expected %h got %h",
               words_seen, what, want, got);
    end
    mismatches++;
  endtask

  // Check each channel word against the oldest one due.
  always @(posedge clk_i) begin
    if (rst_ni && word_valid && word_ready) begin
      if (chan_words_due.size() == 0) begin
        flag_mismatch("word with none due, channel", '0, ACC_W'(word_chan));
      end else begin
        due = chan_words_due.pop_front();
        if (word_sum !== due.sum) flag_mismatch("channel_sum", due.sum, word_sum);
        if (word_chan !== due.chan) begin
          flag_mismatch("channel_number", ACC_W'(due.chan), ACC_W'(word_chan));
        end
        if (word_last !== due.last) begin
          flag_mismatch("last_channel", ACC_W'(due.last), ACC_W'(word_last));
        end
      end
      words_seen++;
    end
  end

  // Receiver: short random stalls, one long hold on request, none in the tail of the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        word_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES - 1;
        word_ready <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        word_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 7);
        word_ready <= 1'b0;
      end else begin
        word_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) cycle_count++;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned phase_no;
    int unsigned directed_bins;
    plan = '{
      // power-on settings: three bins land in channels 0..2
      '{ROW_BIN,   '0,                  28'h07FFFFF, 1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0800000, 1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0000001, 1'b0, '0},
      // shorten the vector below the bin count: the next bin closes it
      '{ROW_WRITE, REG_BINS_PER_VECTOR, 28'd2,       1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0000005, 1'b0, '0},
      // zero counts act as one: one bin, one channel word
      '{ROW_WRITE, REG_NUM_CHANNELS,    28'd0,       1'b0, '0},
      '{ROW_WRITE, REG_BINS_PER_VECTOR, 28'd0,       1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0800000, 1'b1, 40'hFF_FF80_0000},
      '{ROW_BIN,   '0,                  28'h07FFFFF, 1'b1, 40'h00_007F_FFFF},
      // below the band start, one channel and one LSB short
      '{ROW_WRITE, REG_FIRST_BIN_POS,   28'hFFF0000, 1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0123456, 1'b1, '0},
      '{ROW_WRITE, REG_FIRST_BIN_POS,   28'hFFFFFFF, 1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0400000, 1'b1, '0},
      // widest band, bin sits exactly on the limit
      '{ROW_WRITE, REG_BAND_LIMIT,      28'h7FFFFFF, 1'b0, '0},
      '{ROW_WRITE, REG_FIRST_BIN_POS,   28'h7FFFFFF, 1'b0, '0},
      '{ROW_BIN,   '0,                  28'h07FFFFF, 1'b1, '0},
      '{ROW_WRITE, REG_FIRST_BIN_POS,   28'h8000000, 1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0800000, 1'b1, '0},
      // empty band, then the narrowest band that still holds position zero
      '{ROW_WRITE, REG_FIRST_BIN_POS,   28'd0,       1'b0, '0},
      '{ROW_WRITE, REG_BAND_LIMIT,      28'd0,       1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0555555, 1'b1, '0},
      '{ROW_WRITE, REG_BAND_LIMIT,      28'd1,       1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0AAAAAA, 1'b1, 40'hFF_FFAA_AAAA},
      // writes to unmapped indexes change nothing
      '{ROW_WRITE, REG_SPARE_LO,        28'hFFFFFFF, 1'b0, '0},
      '{ROW_WRITE, REG_SPARE_HI,        28'hFFFFFFF, 1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0000003, 1'b1, 40'd3},
      // oversized counts clamp; zero step piles bins into channel 0
      '{ROW_WRITE, REG_BAND_LIMIT,      28'h0400000, 1'b0, '0},
      '{ROW_WRITE, REG_NUM_CHANNELS,    28'h000007F, 1'b0, '0},
      '{ROW_WRITE, REG_BINS_PER_VECTOR, 28'h00007FF, 1'b0, '0},
      '{ROW_WRITE, REG_BIN_STEP,        28'd0,       1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0123456, 1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0654321, 1'b0, '0},
      // widest step takes effect on the next bin; new start waits for the next vector
      '{ROW_WRITE, REG_BIN_STEP,        28'h0FFFFFF, 1'b0, '0},
      '{ROW_BIN,   '0,                  28'h07FFFFF, 1'b0, '0},
      '{ROW_BIN,   '0,                  28'h00ABCDE, 1'b0, '0},
      '{ROW_WRITE, REG_FIRST_BIN_POS,   28'h0050000, 1'b0, '0},
      '{ROW_WRITE, REG_BINS_PER_VECTOR, 28'd3,       1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0000007, 1'b0, '0},
      '{ROW_BIN,   '0,                  28'h07FFFFF, 1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0800000, 1'b0, '0},
      '{ROW_BIN,   '0,                  28'h0000009, 1'b0, '0}
    };

    bpv_reg   = BPV_W'(MAX_BINS_C);
    nch_reg   = NCH_W'(MAX_CH_C);
    first_reg = '0;
    step_reg  = STEP_W'(ONE_CH);
    limit_reg = LIMIT_W'(64 * ONE_CH);
    bin_idx   = 0;
    bin_pos   = '0;
    for (r = 0; r < MAX_CH_C; r++) chan_acc[r] = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind == ROW_WRITE) begin
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        send_bin(plan[r].data[SAMPLE_W-1:0]);
        if (plan[r].typed) begin
          chan_words_due[chan_words_due.size() - 1] = '{plan[r].sum, CH_NUM_W'(0), 1'b1};
        end
      end
    end
    directed_bins = bins_sent;

    phase_no = 0;
    while (bins_sent < directed_bins + RANDOM_BINS) begin
      quiet_tail = (bins_sent - directed_bins) >= (RANDOM_BINS * 4) / 5;
      run_phase(phase_no == 0, directed_bins + RANDOM_BINS - bins_sent);
      phase_no++;
    end

    settle();
    $display("Sent %0d bins (%0d from the table) in %0d random phases, %0d register writes;",
             bins_sent, directed_bins, phase_no, cfg_writes);
    $display("checked %0d channel words, %0d mismatches.", words_seen, mismatches);
    if (mismatches == 0 && chan_words_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
